@@ hdl/vrp_pkg.sv @@
package vrp_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} vrp_op_t;

	// cpu-visible register indexes
	localparam logic [4:0] REG_CTRL     = 5'd0;
	localparam logic [4:0] REG_MASK     = 5'd1;
	localparam logic [4:0] REG_STATUS   = 5'd2;
	localparam logic [4:0] REG_OAM_ADDR = 5'd3;
	localparam logic [4:0] REG_OAM_DATA = 5'd4;
	localparam logic [4:0] REG_SCROLL   = 5'd5;
	localparam logic [4:0] REG_ADDR     = 5'd6;
	localparam logic [4:0] REG_DATA     = 5'd7;
	localparam logic [4:0] REG_DMA      = 5'd20;

	// configuration register indexes
	localparam logic [7:0] CFG_HIT_CYCLE   = 8'd0;
	localparam logic [7:0] CFG_VBLANK_CYCLE = 8'd1;
	localparam logic [7:0] CFG_FRAME_CYCLES = 8'd2;

	// configuration reset values
	localparam logic [14:0] HIT_CYCLE_RST    = 15'd27248;
	localparam logic [14:0] VBLANK_CYCLE_RST = 15'd27428;
	localparam logic [14:0] FRAME_CYCLES_RST = 15'd29694;

	// control and mask bit positions
	localparam int CTRL_INC32_BIT  = 2;
	localparam int CTRL_NMI_BIT    = 7;
	localparam int MASK_SPRITE_BIT = 4;

	localparam logic [15:0] VADDR_STEP_ROW = 16'd32;
	localparam logic [15:0] VADDR_STEP_COL = 16'd1;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] reg_index;
		logic [7:0] write_value;
	} vrp_item_t;

	typedef struct packed {
		logic [7:0]  read_value;
		logic        irq_pulse;
		logic        vram_write_strobe;
		logic [15:0] vram_target;
		logic        sprite_mem_strobe;
		logic [7:0]  sprite_mem_slot;
		logic [7:0]  store_byte;
		logic        dma_request;
		logic [7:0]  dma_source_page;
	} vrp_result_t;

	// frame timer events for the current counter value
	typedef struct packed {
		logic frame_start;
		logic hit_set;
		logic vblank_set;
	} vrp_evt_t;

endpackage

@@ hdl/vrp_req_if.sv @@
interface vrp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [4:0] reg_index;
	logic [7:0] write_value;

	modport source(output valid, operation, reg_index, write_value, input ready);
	modport sink(input valid, operation, reg_index, write_value, output ready);
endinterface

@@ hdl/vrp_rsp_if.sv @@
interface vrp_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_value;
	logic        irq_pulse;
	logic        vram_write_strobe;
	logic [15:0] vram_target;
	logic        sprite_mem_strobe;
	logic [7:0]  sprite_mem_slot;
	logic [7:0]  store_byte;
	logic        dma_request;
	logic [7:0]  dma_source_page;

	modport source(output valid, read_value, irq_pulse, vram_write_strobe, vram_target,
		sprite_mem_strobe, sprite_mem_slot, store_byte, dma_request, dma_source_page,
		input ready);
	modport sink(input valid, read_value, irq_pulse, vram_write_strobe, vram_target,
		sprite_mem_strobe, sprite_mem_slot, store_byte, dma_request, dma_source_page,
		output ready);
endinterface

@@ hdl/vrp_cfg_if.sv @@
interface vrp_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [14:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/video_register_port_frame_timer_top.sv @@
// path: an accepted item is held in the input register and its result is then
//   offered from the result register
// throughput: one item per cycle, limited only by the output handshake
// reset: arst_n clears all state but the item and result data registers, loads
//   the default frame timing, no sweep
module video_register_port_frame_timer_top
	import vrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	vrp_req_if.sink   req,
	vrp_rsp_if.source rsp,
	vrp_cfg_if.sink   cfg
);

	vrp_item_t   item_s1;
	logic        valid_s1;
	logic        valid_q;
	logic        adv;
	logic        tick_en;
	logic        sprites_hidden;
	vrp_evt_t    evt;
	vrp_result_t res_q;

	// pipeline flow
	assign adv       = valid_s1 && (!valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;
	assign tick_en   = adv && (item_s1.operation == OP_TICK);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{operation: req.operation, reg_index: req.reg_index,
				write_value: req.write_value};
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	vrp_timer u_timer (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg.valid && cfg.ready),
		.cfg_idx        (cfg.index),
		.cfg_data       (cfg.data),
		.tick_en        (tick_en),
		.sprites_hidden (sprites_hidden),
		.evt            (evt)
	);

	vrp_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (adv),
		.item           (item_s1),
		.evt            (evt),
		.sprites_hidden (sprites_hidden),
		.res_q          (res_q)
	);

	// result outputs
	assign rsp.valid             = valid_q;
	assign rsp.read_value        = res_q.read_value;
	assign rsp.irq_pulse         = res_q.irq_pulse;
	assign rsp.vram_write_strobe = res_q.vram_write_strobe;
	assign rsp.vram_target       = res_q.vram_target;
	assign rsp.sprite_mem_strobe = res_q.sprite_mem_strobe;
	assign rsp.sprite_mem_slot   = res_q.sprite_mem_slot;
	assign rsp.store_byte        = res_q.store_byte;
	assign rsp.dma_request       = res_q.dma_request;
	assign rsp.dma_source_page   = res_q.dma_source_page;

	// at most one kind of store per item
	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.vram_write_strobe && rsp.sprite_mem_strobe))
		else $error("video and sprite store in one item");

	// interrupt only on a tick, never together with a write effect
	a_irq_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.irq_pulse |->
			!rsp.vram_write_strobe && !rsp.sprite_mem_strobe && !rsp.dma_request)
		else $error("interrupt pulse on a register access");

	// input side stalls only behind a full, blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_q && !rsp.ready)
		else $error("input stalled without back pressure");

	// a held item is not lost while the output is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input register dropped an item");

endmodule

@@ hdl/vrp_timer.sv @@
module vrp_timer
	import vrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_idx,
	input  logic [14:0] cfg_data,
	input  logic        tick_en,
	input  logic        sprites_hidden,
	output vrp_evt_t    evt
);

	logic [14:0] hit_cycle_q;
	logic [14:0] vblank_cycle_q;
	logic [14:0] frame_cycles_q;
	logic [14:0] frame_cycle_q;
	logic [14:0] hit_latched_q;
	logic [14:0] hit_cmp;
	logic [15:0] cycle_inc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cycle_q    <= HIT_CYCLE_RST;
			vblank_cycle_q <= VBLANK_CYCLE_RST;
			frame_cycles_q <= FRAME_CYCLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_HIT_CYCLE:    hit_cycle_q    <= cfg_data;
				CFG_VBLANK_CYCLE: vblank_cycle_q <= cfg_data;
				CFG_FRAME_CYCLES: frame_cycles_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// events at the current counter value; hit cycle is relatched at frame start
	always_comb begin
		evt.frame_start = (frame_cycle_q == '0);
		hit_cmp = evt.frame_start ? (sprites_hidden ? '0 : hit_cycle_q) : hit_latched_q;
		evt.hit_set     = (frame_cycle_q == hit_cmp);
		evt.vblank_set  = (frame_cycle_q == vblank_cycle_q);
		cycle_inc       = {1'b0, frame_cycle_q} + 16'd1;
	end

	// frame counter with wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cycle_q <= '0;
			hit_latched_q <= '0;
		end else if (tick_en) begin
			if (evt.frame_start) begin
				hit_latched_q <= hit_cmp;
			end
			if (cycle_inc >= {1'b0, frame_cycles_q}) begin
				frame_cycle_q <= '0;
			end else begin
				frame_cycle_q <= cycle_inc[14:0];
			end
		end
	end

endmodule

@@ hdl/vrp_core.sv @@
module vrp_core
	import vrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  vrp_item_t   item,
	input  vrp_evt_t    evt,
	output logic        sprites_hidden,
	output vrp_result_t res_q
);

	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  mask_q, mask_d;
	logic        vblank_q, vblank_d;
	logic        hit_q, hit_d;
	logic [7:0]  oam_addr_q, oam_addr_d;
	logic [15:0] vaddr_q, vaddr_d;
	logic        hi_next_q, hi_next_d;
	logic [7:0]  last_oam_q, last_oam_d;
	logic [7:0]  last_vram_q, last_vram_d;
	vrp_result_t res_d;

	assign sprites_hidden = mask_q[MASK_SPRITE_BIT];

	// decode one item into next state and its result
	always_comb begin
		ctrl_d      = ctrl_q;
		mask_d      = mask_q;
		vblank_d    = vblank_q;
		hit_d       = hit_q;
		oam_addr_d  = oam_addr_q;
		vaddr_d     = vaddr_q;
		hi_next_d   = hi_next_q;
		last_oam_d  = last_oam_q;
		last_vram_d = last_vram_q;
		res_d       = '0;
		case (item.operation)
			OP_TICK: begin
				if (evt.frame_start) begin
					hit_d    = 1'b0;
					vblank_d = 1'b0;
				end
				if (evt.hit_set) begin
					hit_d = 1'b1;
				end
				if (evt.vblank_set) begin
					vblank_d        = 1'b1;
					res_d.irq_pulse = ctrl_q[CTRL_NMI_BIT];
				end
			end
			OP_WRITE: begin
				unique case (item.reg_index)
					REG_CTRL:     ctrl_d     = item.write_value;
					REG_MASK:     mask_d     = item.write_value;
					REG_OAM_ADDR: oam_addr_d = item.write_value;
					REG_OAM_DATA: begin
						res_d.sprite_mem_strobe = 1'b1;
						res_d.sprite_mem_slot   = oam_addr_q;
						res_d.store_byte        = item.write_value;
						last_oam_d              = item.write_value;
						oam_addr_d              = oam_addr_q + 8'd1;
					end
					REG_SCROLL: hi_next_d = ~hi_next_q;
					REG_ADDR: begin
						if (hi_next_q) begin
							vaddr_d = {item.write_value, vaddr_q[7:0]};
						end else begin
							vaddr_d = {vaddr_q[15:8], item.write_value};
						end
						hi_next_d = ~hi_next_q;
					end
					REG_DATA: begin
						res_d.vram_write_strobe = 1'b1;
						res_d.vram_target       = vaddr_q;
						res_d.store_byte        = item.write_value;
						last_vram_d             = item.write_value;
						vaddr_d = vaddr_q + (ctrl_q[CTRL_INC32_BIT] ? VADDR_STEP_ROW
							: VADDR_STEP_COL);
					end
					REG_DMA: begin
						res_d.dma_request     = 1'b1;
						res_d.dma_source_page = item.write_value;
					end
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (item.reg_index)
					REG_STATUS: begin
						res_d.read_value = {vblank_q, hit_q, 6'd0};
						vblank_d         = 1'b0;
					end
					REG_OAM_DATA: res_d.read_value = last_oam_q;
					REG_DATA:     res_d.read_value = last_vram_q;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			mask_q      <= '0;
			vblank_q    <= 1'b0;
			hit_q       <= 1'b0;
			oam_addr_q  <= '0;
			vaddr_q     <= '0;
			hi_next_q   <= 1'b1;
			last_oam_q  <= '0;
			last_vram_q <= '0;
		end else if (load) begin
			ctrl_q      <= ctrl_d;
			mask_q      <= mask_d;
			vblank_q    <= vblank_d;
			hit_q       <= hit_d;
			oam_addr_q  <= oam_addr_d;
			vaddr_q     <= vaddr_d;
			hi_next_q   <= hi_next_d;
			last_oam_q  <= last_oam_d;
			last_vram_q <= last_vram_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

@@ tb/video_register_port_frame_timer_top_test.sv @@
module video_register_port_frame_timer_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vrp_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [7:0] CFG_UNKNOWN = 8'd3;
	localparam int         STALL_PCT   = 17;
	localparam int         SETTLE      = 4;
	localparam int         MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	vrp_req_if req_if();
	vrp_rsp_if rsp_if();
	vrp_cfg_if cfg_if();

	video_register_port_frame_timer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// cpu accesses waiting to be sent, results owed by the block
	vrp_item_t   cpu_accesses[$];
	vrp_result_t due_results[$];
	int          fail_cnt;
	int          result_cnt;
	bit          steady;

	// frame timing settings as the block should hold them
	logic [14:0] hit_cycle_cfg;
	logic [14:0] vblank_cycle_cfg;
	logic [14:0] frame_len_cfg;

	// register port and frame timer state
	logic [7:0]  ctrl_q;
	logic [7:0]  mask_q;
	logic        vblank_q;
	logic        hit_q;
	logic [7:0]  oam_addr_q;
	logic [15:0] vaddr_q;
	logic        hi_next_q;
	logic [7:0]  oam_last_q;
	logic [7:0]  vram_last_q;
	logic [14:0] frame_pos_q;
	logic [14:0] hit_latch_q;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// compute the result of one cpu access and advance the state
	function automatic vrp_result_t port_response(vrp_item_t acc);
		vrp_result_t r;
		logic [15:0] nxt;
		r = '0;
		case (acc.operation)
			OP_TICK: begin
				if (frame_pos_q == 15'd0) begin
					hit_q = 1'b0;
					vblank_q = 1'b0;
					hit_latch_q = mask_q[MASK_SPRITE_BIT] ? 15'd0 : hit_cycle_cfg;
				end
				if (frame_pos_q == hit_latch_q)
					hit_q = 1'b1;
				if (frame_pos_q == vblank_cycle_cfg) begin
					vblank_q = 1'b1;
					r.irq_pulse = ctrl_q[CTRL_NMI_BIT];
				end
				nxt = {1'b0, frame_pos_q} + 16'd1;
				frame_pos_q = (nxt >= {1'b0, frame_len_cfg}) ? 15'd0 : nxt[14:0];
			end
			OP_WRITE: begin
				case (acc.reg_index)
					REG_CTRL:     ctrl_q = acc.write_value;
					REG_MASK:     mask_q = acc.write_value;
					REG_OAM_ADDR: oam_addr_q = acc.write_value;
					REG_OAM_DATA: begin
						r.sprite_mem_strobe = 1'b1;
						r.sprite_mem_slot = oam_addr_q;
						r.store_byte = acc.write_value;
						oam_last_q = acc.write_value;
						oam_addr_q = oam_addr_q + 8'd1;
					end
					REG_SCROLL:   hi_next_q = ~hi_next_q;
					REG_ADDR: begin
						if (hi_next_q)
							vaddr_q = {acc.write_value, vaddr_q[7:0]};
						else
							vaddr_q = {vaddr_q[15:8], acc.write_value};
						hi_next_q = ~hi_next_q;
					end
					REG_DATA: begin
						r.vram_write_strobe = 1'b1;
						r.vram_target = vaddr_q;
						r.store_byte = acc.write_value;
						vram_last_q = acc.write_value;
						vaddr_q = vaddr_q + (ctrl_q[CTRL_INC32_BIT] ? VADDR_STEP_ROW
							: VADDR_STEP_COL);
					end
					REG_DMA: begin
						r.dma_request = 1'b1;
						r.dma_source_page = acc.write_value;
					end
					default: ;
				endcase
			end
			OP_READ: begin
				case (acc.reg_index)
					REG_STATUS: begin
						r.read_value = {vblank_q, hit_q, 6'd0};
						vblank_q = 1'b0;
					end
					REG_OAM_DATA: r.read_value = oam_last_q;
					REG_DATA:     r.read_value = vram_last_q;
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void apply_timing(logic [7:0] idx, logic [14:0] val);
		case (idx)
			CFG_HIT_CYCLE:    hit_cycle_cfg = val;
			CFG_VBLANK_CYCLE: vblank_cycle_cfg = val;
			CFG_FRAME_CYCLES: frame_len_cfg = val;
			default: ;
		endcase
	endfunction

	function automatic vrp_item_t mk_access(logic [1:0] op, logic [4:0] idx, logic [7:0] val);
		vrp_item_t a;
		a.operation = op;
		a.reg_index = idx;
		a.write_value = val;
		return a;
	endfunction

	// mostly ticks and legal register traffic, a little noise
	function automatic vrp_item_t random_access();
		int roll;
		logic [4:0] idx;
		roll = $urandom_range(99);
		if (roll < 45)
			return mk_access(OP_TICK, 5'($urandom_range(31)), 8'($urandom_range(255)));
		if (roll < 80) begin
			case ($urandom_range(8))
				0: idx = REG_CTRL;
				1: idx = REG_MASK;
				2: idx = REG_OAM_ADDR;
				3: idx = REG_OAM_DATA;
				4: idx = REG_SCROLL;
				5: idx = REG_ADDR;
				6: idx = REG_DATA;
				7: idx = REG_DMA;
				default: idx = REG_STATUS;
			endcase
			return mk_access(OP_WRITE, idx, 8'($urandom_range(255)));
		end
		if (roll < 95) begin
			case ($urandom_range(3))
				0: idx = REG_OAM_DATA;
				1: idx = REG_DATA;
				default: idx = REG_STATUS;
			endcase
			return mk_access(OP_READ, idx, 8'($urandom_range(255)));
		end
		return mk_access(2'($urandom_range(3)), 5'($urandom_range(31)),
			8'($urandom_range(255)));
	endfunction

	function automatic string fmt_result(vrp_result_t r);
		return $sformatf("rd=%02h irq=%0d vw=%0d va=%04h sw=%0d slot=%02h byte=%02h dma=%0d pg=%02h",
			r.read_value, r.irq_pulse, r.vram_write_strobe, r.vram_target,
			r.sprite_mem_strobe, r.sprite_mem_slot, r.store_byte, r.dma_request,
			r.dma_source_page);
	endfunction

	// wait until every access is sent and answered, then let the pipe settle
	task automatic wait_idle();
		while (cpu_accesses.size() != 0 || due_results.size() != 0 || req_if.valid)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_timing(logic [7:0] idx, logic [14:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		apply_timing(idx, val);
	endtask

	task automatic set_timing(logic [14:0] hit_c, logic [14:0] vbl_c, logic [14:0] len);
		write_timing(CFG_HIT_CYCLE, hit_c);
		write_timing(CFG_VBLANK_CYCLE, vbl_c);
		write_timing(CFG_FRAME_CYCLES, len);
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		@(negedge clk);
		repeat (n) cpu_accesses.push_back(random_access());
		wait_idle();
	endtask

	// access driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready)
				due_results.push_back(port_response(cpu_accesses.pop_front()));
			if (!req_if.valid || req_if.ready) begin
				if (cpu_accesses.size() != 0 && (steady || $urandom_range(99) >= STALL_PCT)) begin
					req_if.valid <= 1'b1;
					req_if.operation <= cpu_accesses[0].operation;
					req_if.reg_index <= cpu_accesses[0].reg_index;
					req_if.write_value <= cpu_accesses[0].write_value;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk) begin : result_mon
		vrp_result_t got;
		vrp_result_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.read_value = rsp_if.read_value;
				got.irq_pulse = rsp_if.irq_pulse;
				got.vram_write_strobe = rsp_if.vram_write_strobe;
				got.vram_target = rsp_if.vram_target;
				got.sprite_mem_strobe = rsp_if.sprite_mem_strobe;
				got.sprite_mem_slot = rsp_if.sprite_mem_slot;
				got.store_byte = rsp_if.store_byte;
				got.dma_request = rsp_if.dma_request;
				got.dma_source_page = rsp_if.dma_source_page;
				if (due_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("unexpected result %0d: %s", result_cnt, fmt_result(got));
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display("result %0d mismatch\n  exp %s\n  got %s", result_cnt,
								fmt_result(want), fmt_result(got));
					end
				end
				result_cnt++;
			end
			rsp_if.ready <= steady || $urandom_range(99) >= STALL_PCT;
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		fail_cnt = 0;
		result_cnt = 0;
		req_if.valid = 1'b0;
		req_if.operation = OP_TICK;
		req_if.reg_index = '0;
		req_if.write_value = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;

		hit_cycle_cfg = HIT_CYCLE_RST;
		vblank_cycle_cfg = VBLANK_CYCLE_RST;
		frame_len_cfg = FRAME_CYCLES_RST;
		ctrl_q = '0;
		mask_q = '0;
		vblank_q = 1'b0;
		hit_q = 1'b0;
		oam_addr_q = '0;
		vaddr_q = '0;
		hi_next_q = 1'b1;
		oam_last_q = '0;
		vram_last_q = '0;
		frame_pos_q = '0;
		hit_latch_q = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reads after reset, address wrap, both increments, toggle, dma, ignored accesses
		cpu_accesses.push_back(mk_access(OP_READ, REG_STATUS, 8'h00));
		cpu_accesses.push_back(mk_access(OP_READ, REG_OAM_DATA, 8'h00));
		cpu_accesses.push_back(mk_access(OP_READ, REG_DATA, 8'hff));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_CTRL, 8'h84));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_MASK, 8'h10));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_OAM_ADDR, 8'hff));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_OAM_DATA, 8'ha5));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_OAM_DATA, 8'h00));
		cpu_accesses.push_back(mk_access(OP_READ, REG_OAM_DATA, 8'h00));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_ADDR, 8'hff));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_ADDR, 8'hff));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_DATA, 8'h3c));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_CTRL, 8'h00));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_DATA, 8'hff));
		cpu_accesses.push_back(mk_access(OP_READ, REG_DATA, 8'h00));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_SCROLL, 8'h12));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_ADDR, 8'hab));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_DMA, 8'h00));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_DMA, 8'hff));
		cpu_accesses.push_back(mk_access(OP_WRITE, REG_STATUS, 8'h55));
		cpu_accesses.push_back(mk_access(OP_WRITE, 5'd31, 8'hff));
		cpu_accesses.push_back(mk_access(OP_READ, REG_CTRL, 8'h00));
		cpu_accesses.push_back(mk_access(OP_READ, 5'd31, 8'h00));
		cpu_accesses.push_back(mk_access(OP_UNUSED, REG_DATA, 8'hff));
		cpu_accesses.push_back(mk_access(OP_TICK, 5'd31, 8'hff));
		cpu_accesses.push_back(mk_access(OP_TICK, 5'd0, 8'h00));
		cpu_accesses.push_back(mk_access(OP_READ, REG_STATUS, 8'h00));
		wait_idle();

		// short frame, no stalls on either side
		steady = 1'b1;
		set_timing(15'd3, 15'd5, 15'd8);
		run_random(200);
		steady = 1'b0;

		// frame length of one with both events at count zero; unknown index is ignored
		set_timing(15'd0, 15'd0, 15'd1);
		write_timing(CFG_UNKNOWN, 15'h7fff);
		run_random(150);

		// zero-length frame, events at the far end
		set_timing(15'h7fff, 15'h7fff, 15'd0);
		run_random(100);

		// events at or past the frame end never fire, but for the hit at frame start while sprites are hidden
		set_timing(15'd20, 15'd10, 15'd10);
		run_random(200);

		// longest frame
		set_timing(15'd2, 15'd4, 15'h7fff);
		run_random(150);

		repeat (3) begin
			set_timing(15'($urandom_range(12)), 15'($urandom_range(12)),
				15'($urandom_range(12, 1)));
			run_random(200);
		end

		repeat (10) @(posedge clk);
		fail_cnt += due_results.size();
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule
